@@ rtl/kslm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kslm_pkg
// Shared types and constants for the serial keyboard link with key matrix.
// ----------------------------------------------------------------------------
package kslm_pkg;

  // matrix geometry
  localparam int ROW_COUNT  = 8;
  localparam int ROW_IDX_W  = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
  localparam int ROW_W      = 16;
  localparam int COL_W      = 4;
  localparam int ROW_SEL_W  = 3;

  // field widths
  localparam int REQ_W      = 3;
  localparam int BYTE_W     = 8;
  localparam int MS_W       = 16;
  localparam int CFG_DATA_W = 16;
  localparam int POS_W      = 3;

  // protocol constants
  localparam logic [BYTE_W-1:0] KEY_LIMIT    = 8'h7F;
  localparam logic [POS_W-1:0]  SEND_FIRST   = 3'd7;
  localparam logic [MS_W-1:0]   MS_MAX       = 16'hFFFF;
  localparam logic [MS_W-1:0]   TIMEOUT_INIT = 16'd1000;

  // configuration register indexes
  typedef enum logic [0:0] {
    CFG_LED_BUZZER = 1'b0,
    CFG_TIMEOUT    = 1'b1
  } cfg_idx_t;

  // event codes
  typedef enum logic [REQ_W-1:0] {
    REQ_CLK_RISE = 3'd0,
    REQ_CLK_FALL = 3'd1,
    REQ_IRQ_RISE = 3'd2,
    REQ_IRQ_FALL = 3'd3,
    REQ_MS_TICK  = 3'd4,
    REQ_READ_ROW = 3'd5
  } req_t;

  // link protocol states
  typedef enum logic [1:0] {
    ST_INVALID   = 2'd0,
    ST_IDLE      = 2'd1,
    ST_RECEIVING = 2'd2,
    ST_SENDING   = 2'd3
  } link_state_t;

  typedef logic [ROW_IDX_W-1:0] row_idx_t;

  // link controller to matrix
  typedef struct packed {
    logic                 clear;
    logic                 toggle;
    logic                 read;
    logic [ROW_SEL_W-1:0] addr;
    logic [COL_W-1:0]     col;
  } mat_ctrl_t;

  // per-event result, without the row bits
  typedef struct packed {
    logic                 so_level;
    logic                 reset_pulse;
    logic                 byte_done;
    logic [BYTE_W-1:0]    byte_value;
    logic                 is_ident;
    logic                 row_valid;
    logic [ROW_SEL_W-1:0] row_index;
    logic                 send_done;
  } link_res_t;

endpackage

@@ rtl/kslm_link.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kslm_link
// Link protocol controller: receive shifter, send sequencer, idle timeout.
// ----------------------------------------------------------------------------
module kslm_link (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             en,
  input  logic [kslm_pkg::REQ_W-1:0]       req,
  input  logic                             si,
  input  logic [kslm_pkg::ROW_SEL_W-1:0]   rsel,
  input  logic [kslm_pkg::BYTE_W-1:0]      led_buzzer_bits,
  input  logic [kslm_pkg::MS_W-1:0]        timeout_ms,
  output kslm_pkg::mat_ctrl_t              mat_ctrl,
  output kslm_pkg::link_res_t              res
);

  kslm_pkg::link_state_t            link_state, link_state_next;
  logic [kslm_pkg::BYTE_W-1:0]      shift_in, shift_in_next;
  logic [kslm_pkg::POS_W-1:0]       send_position, send_position_next;
  logic                             out_level, out_level_next;
  logic                             ident_seen, ident_seen_next;
  logic [kslm_pkg::MS_W-1:0]        quiet_ms, quiet_ms_next;
  logic [kslm_pkg::MS_W-1:0]        quiet_inc;
  logic                             timeout_hit;
  logic                             key_row_ok;
  kslm_pkg::req_t                   req_e;

  assign req_e = kslm_pkg::req_t'(req);

  // saturating tick count and timeout compare
  assign quiet_inc   = (quiet_ms == kslm_pkg::MS_MAX) ? quiet_ms : quiet_ms + 1'b1;
  assign timeout_hit = quiet_inc > timeout_ms;

  // key code row must fall inside the matrix
  assign key_row_ok = 32'(shift_in[6:4]) < kslm_pkg::ROW_COUNT;

  // next protocol state
  always_comb begin
    link_state_next = link_state;
    case (req_e)
      kslm_pkg::REQ_CLK_RISE: begin
        if (link_state == kslm_pkg::ST_SENDING && send_position == '0) begin
          link_state_next = kslm_pkg::ST_IDLE;
        end
      end
      kslm_pkg::REQ_CLK_FALL: begin
        if (link_state == kslm_pkg::ST_IDLE) begin
          link_state_next = kslm_pkg::ST_RECEIVING;
        end
      end
      kslm_pkg::REQ_IRQ_RISE: begin
        if (link_state == kslm_pkg::ST_RECEIVING) begin
          link_state_next = kslm_pkg::ST_SENDING;
        end
      end
      kslm_pkg::REQ_MS_TICK: begin
        if (timeout_hit) begin
          link_state_next = kslm_pkg::ST_IDLE;
        end
      end
      default: link_state_next = link_state;
    endcase
  end

  // datapath updates and event outputs
  always_comb begin
    shift_in_next      = shift_in;
    send_position_next = send_position;
    out_level_next     = out_level;
    ident_seen_next    = ident_seen;
    quiet_ms_next      = quiet_ms;
    mat_ctrl           = '0;
    res                = '0;
    case (req_e)
      kslm_pkg::REQ_CLK_RISE: begin
        if (link_state == kslm_pkg::ST_RECEIVING) begin
          shift_in_next = {shift_in[kslm_pkg::BYTE_W-2:0], si};
        end else if (link_state == kslm_pkg::ST_SENDING) begin
          if (send_position == '0) begin
            res.send_done  = 1'b1;
            out_level_next = 1'b1;
          end else begin
            send_position_next = send_position - 1'b1;
          end
        end
      end
      kslm_pkg::REQ_CLK_FALL: begin
        if (link_state == kslm_pkg::ST_SENDING) begin
          out_level_next = led_buzzer_bits[send_position];
        end
      end
      kslm_pkg::REQ_IRQ_RISE: begin
        if (link_state == kslm_pkg::ST_RECEIVING) begin
          out_level_next     = 1'b1;
          send_position_next = kslm_pkg::SEND_FIRST;
        end
      end
      kslm_pkg::REQ_IRQ_FALL: begin
        if (link_state == kslm_pkg::ST_RECEIVING) begin
          out_level_next = 1'b0;
          quiet_ms_next  = '0;
          res.byte_done  = 1'b1;
          res.byte_value = shift_in;
          if (!ident_seen) begin
            ident_seen_next = 1'b1;
            res.is_ident    = 1'b1;
          end else if (shift_in < kslm_pkg::KEY_LIMIT && key_row_ok) begin
            // key make/break toggles one matrix bit
            mat_ctrl.toggle = 1'b1;
            mat_ctrl.addr   = shift_in[6:4];
            mat_ctrl.col    = shift_in[3:0];
            res.row_valid   = 1'b1;
            res.row_index   = shift_in[6:4];
          end
        end
      end
      kslm_pkg::REQ_MS_TICK: begin
        if (timeout_hit) begin
          mat_ctrl.clear  = 1'b1;
          ident_seen_next = 1'b0;
          quiet_ms_next   = '0;
          res.reset_pulse = 1'b1;
        end else begin
          quiet_ms_next = quiet_inc;
        end
      end
      kslm_pkg::REQ_READ_ROW: begin
        mat_ctrl.read = 1'b1;
        mat_ctrl.addr = rsel;
        res.row_valid = 1'b1;
        res.row_index = rsel;
      end
      default: res = '0;
    endcase
    res.so_level = out_level_next;
  end

  // protocol registers
  always_ff @(posedge clk) begin
    if (rst) begin
      link_state    <= kslm_pkg::ST_INVALID;
      shift_in      <= '0;
      send_position <= '0;
      out_level     <= 1'b1;
      ident_seen    <= 1'b0;
      quiet_ms      <= '0;
    end else if (en) begin
      link_state    <= link_state_next;
      shift_in      <= shift_in_next;
      send_position <= send_position_next;
      out_level     <= out_level_next;
      ident_seen    <= ident_seen_next;
      quiet_ms      <= quiet_ms_next;
    end
  end

endmodule

@@ rtl/kslm_matrix.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kslm_matrix
// Key matrix rows: bit toggle, row read and whole-matrix clear.
// ----------------------------------------------------------------------------
module kslm_matrix (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            en,
  input  kslm_pkg::mat_ctrl_t             mat_ctrl,
  output logic [kslm_pkg::ROW_W-1:0]      row_bits
);

  logic [kslm_pkg::ROW_W-1:0] key_rows [kslm_pkg::ROW_COUNT];
  logic                       in_range;
  kslm_pkg::row_idx_t         idx;
  logic [kslm_pkg::ROW_W-1:0] cur_row;
  logic [kslm_pkg::ROW_W-1:0] toggled_row;

  // row lookup, rows past the matrix read as zero
  assign in_range    = 32'(mat_ctrl.addr) < kslm_pkg::ROW_COUNT;
  assign idx         = kslm_pkg::row_idx_t'(mat_ctrl.addr);
  assign cur_row     = in_range ? key_rows[idx] : '0;
  assign toggled_row = cur_row ^ (kslm_pkg::ROW_W'(1) << mat_ctrl.col);

  // row reported with the beat
  always_comb begin
    if (mat_ctrl.toggle) begin
      row_bits = toggled_row;
    end else if (mat_ctrl.read) begin
      row_bits = cur_row;
    end else begin
      row_bits = '0;
    end
  end

  // row storage
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < kslm_pkg::ROW_COUNT; i++) begin
        key_rows[i] <= '0;
      end
    end else if (en) begin
      if (mat_ctrl.clear) begin
        for (int i = 0; i < kslm_pkg::ROW_COUNT; i++) begin
          key_rows[i] <= '0;
        end
      end else if (mat_ctrl.toggle && in_range) begin
        key_rows[idx] <= toggled_row;
      end
    end
  end

endmodule

@@ rtl/keyboard_serial_link_matrix_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyboard_serial_link_matrix_unit
// Host side of a clocked serial keyboard link with an 8 x 16 key matrix.
//
//   channel  direction  handshake            payload
//   in       input      in_valid / in_stall  req_type, si_level, row_select
//   out      output     out_valid/out_stall  so_level .. send_done
//   cfg      input      cfg_we               cfg_index, cfg_data
//
// One event per clock sustained while out is not stalled; each event passes
// through an input register, then the protocol and matrix update that loads
// the result register.
// Synchronous reset puts the link in INVALID with data-out high and clears
// the matrix; configuration returns to led 0, timeout 1000 ms.
// A stall on out holds the result register and backs up into in_stall.
// ----------------------------------------------------------------------------
module keyboard_serial_link_matrix_unit (
  input  logic                              clk,
  input  logic                              rst,
  // event input
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [kslm_pkg::REQ_W-1:0]        req_type,
  input  logic                              si_level,
  input  logic [kslm_pkg::ROW_SEL_W-1:0]    row_select,
  // result output
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              so_level,
  output logic                              reset_pulse,
  output logic                              byte_done,
  output logic [kslm_pkg::BYTE_W-1:0]       byte_value,
  output logic                              is_ident,
  output logic                              row_valid,
  output logic [kslm_pkg::ROW_SEL_W-1:0]    row_index,
  output logic [kslm_pkg::ROW_W-1:0]        row_bits,
  output logic                              send_done,
  // configuration
  input  logic                              cfg_we,
  input  logic [0:0]                        cfg_index,
  input  logic [kslm_pkg::CFG_DATA_W-1:0]   cfg_data
);

  logic                               s1_valid;
  logic [kslm_pkg::REQ_W-1:0]         s1_req;
  logic                               s1_si;
  logic [kslm_pkg::ROW_SEL_W-1:0]     s1_rsel;
  logic                               advance;
  logic                               in_accept;
  logic [kslm_pkg::BYTE_W-1:0]        led_buzzer_bits;
  logic [kslm_pkg::MS_W-1:0]          timeout_ms;
  kslm_pkg::mat_ctrl_t                mat_ctrl;
  kslm_pkg::link_res_t                res;
  logic [kslm_pkg::ROW_W-1:0]         mat_row_bits;

  // pipeline handshake
  assign advance   = s1_valid && (!out_valid || !out_stall);
  assign in_stall  = s1_valid && !advance;
  assign in_accept = in_valid && !in_stall;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      led_buzzer_bits <= '0;
      timeout_ms      <= kslm_pkg::TIMEOUT_INIT;
    end else if (cfg_we) begin
      case (kslm_pkg::cfg_idx_t'(cfg_index))
        kslm_pkg::CFG_LED_BUZZER: led_buzzer_bits <= cfg_data[kslm_pkg::BYTE_W-1:0];
        kslm_pkg::CFG_TIMEOUT:    timeout_ms      <= cfg_data[kslm_pkg::MS_W-1:0];
        default:                  timeout_ms      <= timeout_ms;
      endcase
    end
  end

  // input register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  // input register payload
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_req  <= req_type;
      s1_si   <= si_level;
      s1_rsel <= row_select;
    end
  end

  kslm_link u_link (
    .clk             (clk),
    .rst             (rst),
    .en              (advance),
    .req             (s1_req),
    .si              (s1_si),
    .rsel            (s1_rsel),
    .led_buzzer_bits (led_buzzer_bits),
    .timeout_ms      (timeout_ms),
    .mat_ctrl        (mat_ctrl),
    .res             (res)
  );

  kslm_matrix u_matrix (
    .clk      (clk),
    .rst      (rst),
    .en       (advance),
    .mat_ctrl (mat_ctrl),
    .row_bits (mat_row_bits)
  );

  // result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (advance) begin
      so_level    <= res.so_level;
      reset_pulse <= res.reset_pulse;
      byte_done   <= res.byte_done;
      byte_value  <= res.byte_value;
      is_ident    <= res.is_ident;
      row_valid   <= res.row_valid;
      row_index   <= res.row_index;
      row_bits    <= mat_row_bits;
      send_done   <= res.send_done;
    end
  end

endmodule

@@ rtl/kslm_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kslm_checker
// Port-level checks for the keyboard link unit, bound to the top level.
// ----------------------------------------------------------------------------
module kslm_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  logic                              so_level,
  input  logic                              reset_pulse,
  input  logic                              byte_done,
  input  logic [kslm_pkg::BYTE_W-1:0]       byte_value,
  input  logic                              is_ident,
  input  logic                              row_valid,
  input  logic [kslm_pkg::ROW_SEL_W-1:0]    row_index,
  input  logic [kslm_pkg::ROW_W-1:0]        row_bits,
  input  logic                              send_done
);

  // a stalled result beat stays put
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(byte_value) && $stable(row_bits)
      && $stable(so_level))
    else $error("stalled result beat changed");

  // byte fields are clear unless a byte completed
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !byte_done |-> byte_value == '0 && !is_ident)
    else $error("byte fields set without byte_done");

  // row fields are clear unless a row is reported
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !row_valid |-> row_index == '0 && row_bits == '0)
    else $error("row fields set without row_valid");

  // a timeout beat carries no other event
  assert property (@(posedge clk) disable iff (rst)
    out_valid && reset_pulse |-> !byte_done && !send_done && !row_valid)
    else $error("timeout beat mixed with another event");

  // end of send leaves data-out high
  assert property (@(posedge clk) disable iff (rst)
    out_valid && send_done |-> so_level && !byte_done)
    else $error("send_done with data-out low");

endmodule

bind keyboard_serial_link_matrix_unit kslm_checker u_kslm_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .so_level    (so_level),
  .reset_pulse (reset_pulse),
  .byte_done   (byte_done),
  .byte_value  (byte_value),
  .is_ident    (is_ident),
  .row_valid   (row_valid),
  .row_index   (row_index),
  .row_bits    (row_bits),
  .send_done   (send_done)
);
